// File: sv/teq_pkg.sv
`default_nettype none
package teq_pkg;

  localparam int unsigned MaxResults = 16;

  localparam logic [1:0] CmdSchedule = 2'd0;
  localparam logic [1:0] CmdTick     = 2'd1;
  localparam logic [1:0] CmdClear    = 2'd2;
  localparam logic [1:0] CmdReserved = 2'd3;

  localparam logic [2:0] StFired     = 3'd0;
  localparam logic [2:0] StScheduled = 3'd1;
  localparam logic [2:0] StDropped   = 3'd2;
  localparam logic [2:0] StCleared   = 3'd3;
  localparam logic [2:0] StNoneDue   = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_time;
    logic [31:0] delay_time;
    logic [15:0] event_id;
    logic [7:0]  dispatcher_id;
    logic [7:0]  event_flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_event_id;
    logic [7:0]  fired_dispatcher;
    logic [7:0]  fired_flags;
    logic [6:0]  removed_count;
    logic        last;
  } out_item_t;

  // fire time 63..32, id 31..16, dispatcher 15..8, flags 7..0
  typedef struct packed {
    logic [31:0] fire_time;
    logic [15:0] event_id;
    logic [7:0]  dispatcher;
    logic [7:0]  flags;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/teq_ram.sv
`default_nettype none
module teq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/timed_event_queue_unit.sv
// Timed event queue: events sorted by fire time in one single-port-read RAM.
// Schedule: result after a read/shift walk from the tail. Clear and drop: result in the
// cycle after the item. Tick: each further fired item comes after the previous is taken;
// then the survivors move down. One item at a time; in_stall_o is high while an item
// is in work or a result waits. Reset (async, active low) empties the queue; RAM
// contents need no clearing.
`default_nettype none
module timed_event_queue_unit #(
  parameter int unsigned QueueDepth = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire teq_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output teq_pkg::out_item_t      out_item_o
);
  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  // a tick fires at most MaxResults events and never more than the queue holds
  localparam int unsigned FireCap = (QueueDepth < teq_pkg::MaxResults) ?
                                    QueueDepth : teq_pkg::MaxResults;

  typedef enum logic [2:0] {
    SIdle, SInsRead, SInsCheck, STickRead, STickCheck, SShiftRead, SShiftWrite, SOut
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   idx_q;     // walk position
  logic [CntW-1:0]   nfire_q;   // events fired by this tick
  logic [31:0]       time_q;    // fire time (schedule) or now (tick)
  teq_pkg::entry_t   new_q;
  teq_pkg::out_item_t res_q;
  logic              pend_q;    // res_q holds a fired item not yet shown

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [63:0]       wdata, rdata;
  teq_pkg::entry_t   rentry;

  teq_ram #(.Width(64), .Depth(QueueDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  assign rentry = teq_pkg::entry_t'(rdata);

  logic [32:0] sum;
  logic [31:0] fire_sat;
  assign sum      = {1'b0, in_item_i.now_time} + {1'b0, in_item_i.delay_time};
  assign fire_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != SIdle) || out_valid_o;

  function automatic teq_pkg::out_item_t plain_res(logic [2:0] st, logic [6:0] removed);
    teq_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.removed_count = removed;
    r.last = 1'b1;
    return r;
  endfunction

  // Read address: insert walks down from idx-1; tick/shift read at idx.
  always_comb begin
    raddr = idx_q[AddrW-1:0];
    if (state_q == SInsRead) raddr = AddrW'(idx_q - CntW'(1));
    we    = 1'b0;
    waddr = idx_q[AddrW-1:0];
    wdata = rdata;
    if (state_q == SInsCheck) begin
      we = 1'b1;
      if (idx_q != '0 && rentry.fire_time > time_q) begin
        wdata = rdata;          // move entry idx-1 up to idx
      end else begin
        wdata = new_q;
      end
    end else if (state_q == SShiftWrite) begin
      we    = 1'b1;
      waddr = AddrW'(idx_q - nfire_q);
    end
  end

  // Tick: each due entry is parked in res_q and shown only once the next entry has
  // been examined or the walk ends, so its last flag is known. A shown item that is not
  // the last must be taken before the walk moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      idx_q       <= '0;
      nfire_q     <= '0;
      time_q      <= '0;
      new_q       <= '0;
      res_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_acc) out_valid_o <= 1'b0;
      case (state_q)
        SIdle: begin
          if (in_acc) begin
            new_q <= '{fire_time: fire_sat,
                       event_id: in_item_i.event_id,
                       dispatcher: in_item_i.dispatcher_id,
                       flags: in_item_i.event_flags};
            case (in_item_i.command)
              teq_pkg::CmdSchedule: begin
                if (count_q >= CntW'(QueueDepth)) begin
                  res_q       <= plain_res(teq_pkg::StDropped, 7'd0);
                  out_valid_o <= 1'b1;
                end else begin
                  time_q  <= fire_sat;
                  idx_q   <= count_q;
                  state_q <= SInsRead;
                end
              end
              teq_pkg::CmdTick: begin
                time_q  <= in_item_i.now_time;
                idx_q   <= '0;
                nfire_q <= '0;
                pend_q  <= 1'b0;
                state_q <= STickRead;
              end
              teq_pkg::CmdClear: begin
                res_q       <= plain_res(teq_pkg::StCleared, 7'(count_q));
                count_q     <= '0;
                out_valid_o <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        SInsRead: state_q <= SInsCheck;
        SInsCheck: begin
          if (idx_q != '0 && rentry.fire_time > time_q) begin
            idx_q   <= idx_q - CntW'(1);
            state_q <= SInsRead;
          end else begin
            count_q     <= count_q + CntW'(1);
            res_q       <= plain_res(teq_pkg::StScheduled, 7'd0);
            out_valid_o <= 1'b1;
            state_q     <= SIdle;
          end
        end
        STickRead: begin
          if (idx_q < count_q && nfire_q < CntW'(FireCap)) begin
            state_q <= STickCheck;
          end else if (pend_q) begin
            res_q.last  <= 1'b1;
            out_valid_o <= 1'b1;
            pend_q      <= 1'b0;
            state_q     <= SShiftRead;   // idx_q == nfire_q
          end else begin
            res_q       <= plain_res(teq_pkg::StNoneDue, 7'd0);
            out_valid_o <= 1'b1;
            state_q     <= SIdle;
          end
        end
        STickCheck: begin
          if (rentry.fire_time <= time_q) begin
            if (pend_q) begin
              // parked item is not the last; show it, then read this entry again
              out_valid_o <= 1'b1;
              pend_q      <= 1'b0;
              state_q     <= SOut;
            end else begin
              res_q <= '{status: teq_pkg::StFired,
                         fired_event_id: rentry.event_id,
                         fired_dispatcher: rentry.dispatcher,
                         fired_flags: rentry.flags,
                         removed_count: 7'd0,
                         last: 1'b0};
              pend_q  <= 1'b1;
              nfire_q <= nfire_q + CntW'(1);
              idx_q   <= idx_q + CntW'(1);
              state_q <= STickRead;
            end
          end else if (pend_q) begin
            res_q.last  <= 1'b1;
            out_valid_o <= 1'b1;
            pend_q      <= 1'b0;
            state_q     <= SShiftRead;
          end else begin
            res_q       <= plain_res(teq_pkg::StNoneDue, 7'd0);
            out_valid_o <= 1'b1;
            state_q     <= SIdle;
          end
        end
        SOut: begin
          if (out_acc) state_q <= STickRead;
        end
        SShiftRead: begin
          if (idx_q < count_q) state_q <= SShiftWrite;
          else begin
            count_q <= count_q - nfire_q;
            state_q <= SIdle;
          end
        end
        SShiftWrite: begin
          idx_q   <= idx_q + CntW'(1);
          state_q <= SShiftRead;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_item_o = res_q;

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QueueDepth);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count overflow");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_acc) else $error("item accepted while busy");

  a_write_only_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == SInsCheck || state_q == SShiftWrite))
    else $error("stray RAM write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");
endmodule
`default_nettype wire
